// ===== design/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

  // Largest screen the parameters allow: 128 columns by 64 rows.
  localparam int COLUMNS_MAX = 128;
  localparam int ROWS_MAX    = 64;
  localparam int AW_MAX      = $clog2(COLUMNS_MAX * ROWS_MAX);

  // Result field widths, fixed by the result format.
  localparam int IDX_W = 11;

  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] COLOR_RESET    = 8'd7;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SETCUR = 2'd1,
    OP_COLOR  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // One classified item, as handed from the front to the back.
  typedef struct packed {
    logic              scroll;
    logic              write;
    logic              clear;
    logic [AW_MAX-1:0] addr;
    logic [7:0]        ch;
    logic [7:0]        color;
    logic [IDX_W-1:0]  cursor;
    logic              accepted;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

// ===== design/tccs_ram.sv =====
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1134
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/tccs_fifo.sv =====
`default_nettype none

module tccs_fifo #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] pdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? PW'(wr_r + PW'(1)) : wr_r;
    rd_nxt  = pop ? PW'(rd_r + PW'(1)) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= pdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/tccs_front.sv =====
`default_nettype none

module tccs_front #(
  parameter int COLUMNS = 42,
  parameter int ROWS    = 27
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [7:0]                 in_char_code,
  input  wire logic [7:0]                 in_column,
  input  wire logic [7:0]                 in_row,
  input  wire logic [7:0]                 in_color,
  input  wire logic                       q_full,
  input  wire tccs_pkg::back_status_t     status,
  output logic                            q_push,
  output tccs_pkg::cmd_t                  q_cmd
);

  import tccs_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CUR_W = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS + 1);

  logic [CUR_W-1:0] cur_r, cur_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       color_r, color_nxt;

  logic [CUR_W-1:0] lin_s;
  logic [ROW_W-1:0] row_s;
  logic             scroll;
  op_t              op;

  assign op       = op_t'(in_operation);
  assign in_stall = q_full || status.init_busy;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    // cursor at end of screen means row == ROWS, column 0
    scroll = (op == OP_PUT) && (cur_r == CUR_W'(CELLS));
    lin_s  = scroll ? CUR_W'(cur_r - CUR_W'(COLUMNS)) : cur_r;
    row_s  = scroll ? ROW_W'(row_r - ROW_W'(1)) : row_r;

    cur_nxt   = cur_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    color_nxt = color_r;

    q_cmd          = '0;
    q_cmd.scroll   = scroll;
    q_cmd.accepted = 1'b1;

    case (op)
      OP_PUT: begin
        cur_nxt = lin_s;
        row_nxt = row_s;
        if (in_char_code == CODE_NEWLINE) begin
          cur_nxt = CUR_W'(lin_s + CUR_W'(COLUMNS) - CUR_W'(col_r));
          col_nxt = '0;
          row_nxt = ROW_W'(row_s + ROW_W'(1));
        end else if (in_char_code == CODE_BACKSPACE) begin
          if (lin_s != '0) begin
            cur_nxt = CUR_W'(lin_s - CUR_W'(1));
            if (col_r == '0) begin
              col_nxt = COL_W'(COLUMNS - 1);
              row_nxt = ROW_W'(row_s - ROW_W'(1));
            end else begin
              col_nxt = COL_W'(col_r - COL_W'(1));
            end
          end
        end else begin
          q_cmd.write = 1'b1;
          q_cmd.addr  = AW_MAX'(lin_s);
          q_cmd.ch    = in_char_code;
          q_cmd.color = color_r;
          cur_nxt     = CUR_W'(lin_s + CUR_W'(1));
          if (col_r == COL_W'(COLUMNS - 1)) begin
            col_nxt = '0;
            row_nxt = ROW_W'(row_s + ROW_W'(1));
          end else begin
            col_nxt = COL_W'(col_r + COL_W'(1));
          end
        end
      end
      OP_SETCUR: begin
        if (({1'b0, in_column} >= 9'(COLUMNS)) || ({1'b0, in_row} >= 9'(ROWS))) begin
          q_cmd.accepted = 1'b0;
        end else begin
          cur_nxt   = CUR_W'(CUR_W'(in_row) * CUR_W'(COLUMNS) + CUR_W'(in_column));
          col_nxt   = COL_W'(in_column);
          row_nxt   = ROW_W'(in_row);
          color_nxt = in_color;
        end
      end
      OP_COLOR: begin
        color_nxt = in_color;
      end
      OP_CLEAR: begin
        q_cmd.clear = 1'b1;
        cur_nxt     = '0;
        col_nxt     = '0;
        row_nxt     = '0;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase

    q_cmd.cursor = IDX_W'(cur_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      color_r <= COLOR_RESET;
    end else if (q_push) begin
      cur_r   <= cur_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tccs_back.sv =====
`default_nettype none

module tccs_back #(
  parameter int COLUMNS = 42,
  parameter int ROWS    = 27
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tccs_pkg::cmd_t                      q_cmd,
  input  wire logic                                q_empty,
  output logic                                     q_pop,
  output tccs_pkg::back_status_t                   status,
  output logic                                     ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]          ram_waddr,
  output logic [15:0]                              ram_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0]          ram_raddr,
  input  wire logic [15:0]                         ram_rdata,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tccs_pkg::IDX_W-1:0]               out_cursor_index,
  output logic                                     out_cell_written,
  output logic [tccs_pkg::IDX_W-1:0]               out_cell_address,
  output logic [7:0]                               out_cell_char,
  output logic [7:0]                               out_cell_color,
  output logic                                     out_scrolled,
  output logic                                     out_accepted
);

  import tccs_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A     = ADDR_W'(CELLS - 1);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCROLL = 6'b000100,
    S_ROWCLR = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  cmd_t              cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  assign status.init_busy = (state_r == S_INIT);
  assign out_valid        = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cur_nxt       = cur_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = '0;
    ram_raddr     = ADDR_W'(ptr_r + ADDR_W'(COLUMNS));
    out_load      = 1'b0;

    case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_r == LAST_A) begin
          ptr_nxt   = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          ptr_nxt = ADDR_W'(ptr_r + ADDR_W'(1));
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_nxt  = q_cmd;
          ptr_nxt  = '0;
          pend_nxt = 1'b0;
          if (q_cmd.clear) begin
            state_nxt = S_CLEAR;
          end else if (q_cmd.scroll) begin
            state_nxt = S_SCROLL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCROLL: begin
        // read one row ahead, write the beat read in the previous cycle
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = ram_rdata;
        end
        if (ptr_r != LAST_ROW_A) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ADDR_W'(ptr_r + ADDR_W'(1));
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_ROWCLR;
          end
        end
      end
      S_ROWCLR: begin
        ram_we = 1'b1;
        if (ptr_r == LAST_A) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ADDR_W'(ptr_r + ADDR_W'(1));
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          ram_we    = cur_r.write;
          ram_waddr = ADDR_W'(cur_r.addr);
          ram_wdata = {cur_r.ch, cur_r.color};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    cur_r       <= cur_nxt;
    if (out_load) begin
      out_cursor_index <= cur_r.cursor;
      out_cell_written <= cur_r.write;
      out_cell_address <= cur_r.addr[IDX_W-1:0];
      out_cell_char    <= cur_r.ch;
      out_cell_color   <= cur_r.color;
      out_scrolled     <= cur_r.scroll;
      out_accepted     <= cur_r.accepted;
    end
  end

endmodule

`default_nettype wire

// ===== design/text_console_cursor_scroll_core.sv =====
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  operation, char_code, column, row, color
// out_     output     out_valid/out_stall  cursor_index, cell_written, cell_address,
//                                          cell_char, cell_color, scrolled, accepted
//
// Front takes one beat a cycle into a two-entry queue while in_stall is low (queue not
// full, init done); back runs one item at a time. Put, set cursor, set colour: dequeue,
// then write cell and load result. Put that scrolls: one cell a cycle through the
// screen RAM, rows moved up and the last row cleared. Clear screen: RAM swept to zero.
// After reset the RAM is swept to zero with in_stall held high. Result sits in an output
// register, so a stalled out_ side holds the back but the front keeps filling the queue.

module text_console_cursor_scroll_core #(
  parameter int COLUMNS = 42,
  parameter int ROWS    = 27
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [7:0]                 in_char_code,
  input  wire logic [7:0]                 in_column,
  input  wire logic [7:0]                 in_row,
  input  wire logic [7:0]                 in_color,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [tccs_pkg::IDX_W-1:0]      out_cursor_index,
  output logic                            out_cell_written,
  output logic [tccs_pkg::IDX_W-1:0]      out_cell_address,
  output logic [7:0]                      out_cell_char,
  output logic [7:0]                      out_cell_color,
  output logic                            out_scrolled,
  output logic                            out_accepted
);

  import tccs_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  cmd_t              push_cmd, head_cmd;
  logic [$bits(cmd_t)-1:0] head_bits;
  logic              q_push, q_pop, q_full, q_empty;
  back_status_t      status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  assign head_cmd = cmd_t'(head_bits);

  tccs_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_color     (in_color),
    .q_full       (q_full),
    .status       (status),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  tccs_fifo #(.WIDTH($bits(cmd_t))) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pdata (push_cmd),
    .pop   (q_pop),
    .rdata (head_bits),
    .full  (q_full),
    .empty (q_empty)
  );

  tccs_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_cmd            (head_cmd),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .status           (status),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cursor_index (out_cursor_index),
    .out_cell_written (out_cell_written),
    .out_cell_address (out_cell_address),
    .out_cell_char    (out_cell_char),
    .out_cell_color   (out_cell_color),
    .out_scrolled     (out_scrolled),
    .out_accepted     (out_accepted)
  );

  // character in the high byte, colour in the low byte
  tccs_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    status.init_busy |-> in_stall)
    else $error("input beat taken during RAM init sweep");

  a_reject_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (!out_cell_written && !out_scrolled))
    else $error("rejected set cursor wrote or scrolled");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CELLS > 2047) || (out_cursor_index <= IDX_W'(CELLS))))
    else $error("cursor beyond end of screen");

  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cell_written) |->
      ((CELLS > 2047) || (out_cell_address < IDX_W'(CELLS))))
    else $error("written cell outside screen");

endmodule

`default_nettype wire

// ===== test/console_screen_checker.sv =====
module console_screen_checker
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 42,
  parameter int ROWS    = 27
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [1:0]        in_operation,
  input  wire logic [7:0]        in_char_code,
  input  wire logic [7:0]        in_column,
  input  wire logic [7:0]        in_row,
  input  wire logic [7:0]        in_color,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [IDX_W-1:0]  out_cursor_index,
  input  wire logic              out_cell_written,
  input  wire logic [IDX_W-1:0]  out_cell_address,
  input  wire logic [7:0]        out_cell_char,
  input  wire logic [7:0]        out_cell_color,
  input  wire logic              out_scrolled,
  input  wire logic              out_accepted,
  output int                     error_count,
  output int                     outstanding
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [IDX_W-1:0] cursor_index;
    logic             cell_written;
    logic [IDX_W-1:0] cell_address;
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
    logic             scrolled;
    logic             accepted;
  } screen_result_t;

  logic [7:0]     char_cells  [CELLS];
  logic [7:0]     color_cells [CELLS];
  int             cursor;
  logic [7:0]     pen_color;
  screen_result_t screen_results_q [$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      char_cells[i]  = '0;
      color_cells[i] = '0;
    end
  endtask

  function automatic screen_result_t console_step(op_t op, logic [7:0] code,
                                                  logic [7:0] col, logic [7:0] row,
                                                  logic [7:0] colr);
    screen_result_t r;
    int i;
    r = '0;
    r.accepted = 1'b1;
    case (op)
      OP_PUT: begin
        // cursor parked one past the end: scroll before handling the code
        if (cursor == CELLS) begin
          for (i = 0; i + COLUMNS < CELLS; i++) begin
            char_cells[i]  = char_cells[i + COLUMNS];
            color_cells[i] = color_cells[i + COLUMNS];
          end
          for (; i < CELLS; i++) begin
            char_cells[i]  = '0;
            color_cells[i] = '0;
          end
          cursor     = cursor - COLUMNS;
          r.scrolled = 1'b1;
        end
        if (code == CODE_NEWLINE) begin
          cursor = cursor + COLUMNS - (cursor % COLUMNS);
        end else if (code == CODE_BACKSPACE) begin
          if (cursor > 0) cursor = cursor - 1;
        end else if (cursor < CELLS) begin
          char_cells[cursor]  = code;
          color_cells[cursor] = pen_color;
          r.cell_written = 1'b1;
          r.cell_address = cursor[IDX_W-1:0];
          r.cell_char    = code;
          r.cell_color   = pen_color;
          cursor = cursor + 1;
        end
      end
      OP_SETCUR: begin
        if (int'(col) >= COLUMNS || int'(row) >= ROWS) begin
          r.accepted = 1'b0;
        end else begin
          cursor    = int'(row) * COLUMNS + int'(col);
          pen_color = colr;
        end
      end
      OP_COLOR: begin
        pen_color = colr;
      end
      default: begin
        for (i = 0; i < CELLS; i++) begin
          char_cells[i]  = '0;
          color_cells[i] = '0;
        end
        cursor = 0;
      end
    endcase
    r.cursor_index = cursor[IDX_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    screen_result_t want;
    if (!rst_n) begin
      blank_screen();
      cursor    = 0;
      pen_color = COLOR_RESET;
      screen_results_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        screen_results_q.push_back(console_step(op_t'(in_operation), in_char_code,
                                                in_column, in_row, in_color));
      end
      if (out_valid && !out_stall) begin
        if (screen_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, cursor %0d",
                   $time, out_cursor_index);
          error_count++;
        end else begin
          want = screen_results_q.pop_front();
          compare_field("cursor_index", want.cursor_index, out_cursor_index);
          compare_field("cell_written", want.cell_written, out_cell_written);
          compare_field("cell_address", want.cell_address, out_cell_address);
          compare_field("cell_char",    want.cell_char,    out_cell_char);
          compare_field("cell_color",   want.cell_color,   out_cell_color);
          compare_field("scrolled",     want.scrolled,     out_scrolled);
          compare_field("accepted",     want.accepted,     out_accepted);
        end
      end
    end
    outstanding <= screen_results_q.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import tccs_pkg::*;

  localparam int COLUMNS     = 42;
  localparam int ROWS        = 27;
  localparam int ITEM_TARGET = 1950;
  localparam int QUIET_LIMIT = 25000;
  localparam int HOLD_CYCLES = 300;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [1:0]       in_operation = OP_PUT;
  logic [7:0]       in_char_code = '0;
  logic [7:0]       in_column    = '0;
  logic [7:0]       in_row       = '0;
  logic [7:0]       in_color     = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [IDX_W-1:0] out_cursor_index;
  logic             out_cell_written;
  logic [IDX_W-1:0] out_cell_address;
  logic [7:0]       out_cell_char;
  logic [7:0]       out_cell_color;
  logic             out_scrolled;
  logic             out_accepted;

  int error_count;
  int outstanding;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit send_gaps = 1'b1;

  text_console_cursor_scroll_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_char_code(in_char_code),
    .in_column(in_column), .in_row(in_row), .in_color(in_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cursor_index(out_cursor_index), .out_cell_written(out_cell_written),
    .out_cell_address(out_cell_address), .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color), .out_scrolled(out_scrolled),
    .out_accepted(out_accepted)
  );

  console_screen_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_char_code(in_char_code),
    .in_column(in_column), .in_row(in_row), .in_color(in_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cursor_index(out_cursor_index), .out_cell_written(out_cell_written),
    .out_cell_address(out_cell_address), .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color), .out_scrolled(out_scrolled),
    .out_accepted(out_accepted),
    .error_count(error_count), .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // one input beat; returns at the edge that takes it
  task automatic send_item(input op_t op, input logic [7:0] code, input logic [7:0] col,
                           input logic [7:0] row, input logic [7:0] colr);
    int gap;
    if (items_sent % 64 == 0) send_gaps = ($urandom_range(0, 3) != 0);
    gap = send_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_char_code <= code;
    in_column    <= col;
    in_row       <= row;
    in_color     <= colr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_char(input logic [7:0] code);
    send_item(OP_PUT, code, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic set_cursor(input int col, input int row, input logic [7:0] colr);
    send_item(OP_SETCUR, 8'($urandom), 8'(col), 8'(row), colr);
  endtask

  task automatic text_line();
    int len;
    len = $urandom_range(1, 60);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) put_char(CODE_BACKSPACE);
      else if ($urandom_range(0, 9) == 0) put_char(8'($urandom));
      else put_char(8'($urandom_range(32, 126)));
    end
    put_char(CODE_NEWLINE);
  endtask

  // result side: random stall per beat, plus two long hold-offs to fill the block
  initial begin
    int gap;
    int beats;
    bit rx_gaps;
    beats = 0;
    rx_gaps = 1'b1;
    @(posedge clk);
    forever begin
      if (beats % 64 == 0) rx_gaps = ($urandom_range(0, 3) != 0);
      gap = rx_gaps ? $urandom_range(0, 6) : 0;
      if (beats == 400 || beats == 1200) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    put_char(CODE_BACKSPACE);               // backspace at cell zero
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CODE_NEWLINE);
    send_item(OP_COLOR, 8'h41, 8'hFF, 8'hFF, 8'h00);
    put_char(8'h61);
    send_item(OP_COLOR, 8'h00, 8'h00, 8'h00, 8'hFF);
    put_char(8'h62);
    set_cursor(0, 0, 8'h5A);
    set_cursor(COLUMNS - 1, ROWS - 1, 8'hA5);
    put_char(8'h5A);                        // last cell, cursor to end
    put_char(8'h59);                        // scroll then write
    set_cursor(COLUMNS, 0, 8'h11);          // rejected: column
    set_cursor(0, ROWS, 8'h22);             // rejected: row
    set_cursor(255, 255, 8'h33);
    set_cursor(0, ROWS - 1, 8'h03);
    put_char(CODE_NEWLINE);                 // newline on last row
    put_char(CODE_NEWLINE);                 // scroll, newline again
    put_char(CODE_BACKSPACE);               // scroll, then back one
    send_item(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    put_char(8'h63);
    set_cursor(COLUMNS - 1, ROWS - 1, 8'h01);
    put_char(8'h71);
    put_char(8'h80);
    send_item(OP_COLOR, 8'hFF, 8'h00, 8'h00, 8'hFF);

    // random: mostly text lines, with cursor moves and some noise
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        text_line();
      end else if (pick < 70) begin
        if ($urandom_range(0, 1) == 0)
          set_cursor($urandom_range(0, COLUMNS - 1), ROWS - 1 - $urandom_range(0, 1),
                     8'($urandom));
        else
          set_cursor($urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1),
                     8'($urandom));
      end else if (pick < 78) begin
        send_item(OP_COLOR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 81) begin
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0)
          set_cursor($urandom_range(COLUMNS, 255), $urandom_range(0, 255), 8'($urandom));
        else
          set_cursor($urandom_range(0, 255), $urandom_range(ROWS, 255), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5))
          send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
